### hw/rtl/assert_macros.svh
// Assertion macros used by the sorted list store datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SLS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sorted list store assertion failed");

// When the trigger holds, the consequence must hold in the next cycle.
`define SLS_ASSERT_NEXT(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("sorted list store assertion failed");

`endif

### hw/rtl/sls_pkg.sv
// Package with types and constants of the sorted list store.
`default_nettype none

package sls_pkg;

   localparam int CAPACITY = 64;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_FIND   = 2'd2,
      CMD_DUMP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_APPLY,
      S_DUMP
   } state_type;

   typedef struct packed {
      cmd_type                    command;
      logic signed [DATA_W-1:0]   value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]   data;
      status_type                 status;
      logic                       found;
      logic [CNT_W-1:0]           occupancy;
      logic                       last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic compare;
      logic apply;
      logic dump_step;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic slot_free;
      logic dump_go;
      logic dump_last;
   } dp_stat_type;

endpackage

`default_nettype wire

### hw/rtl/sls_ctrl.sv
// Controller state machine of the sorted list store.
`default_nettype none

module sls_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire sls_pkg::dp_stat_type stat,
   output sls_pkg::ctrl_cmd_type    cmd
);

   sls_pkg::state_type state_ff;
   sls_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sls_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         sls_pkg::S_IDLE: begin
            // No request is taken while reset is held.
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load_req = 1'b1;
               state_in     = sls_pkg::S_COMPARE;
            end
         end
         sls_pkg::S_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = sls_pkg::S_APPLY;
         end
         sls_pkg::S_APPLY: begin
            // Wait until the output register can take a new result.
            if (stat.slot_free) begin
               cmd.apply = 1'b1;
               state_in  = stat.dump_go ? sls_pkg::S_DUMP : sls_pkg::S_IDLE;
            end
         end
         sls_pkg::S_DUMP: begin
            if (stat.slot_free) begin
               cmd.dump_step = 1'b1;
               if (stat.dump_last) begin
                  state_in = sls_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = sls_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### hw/rtl/sls_datapath.sv
// Datapath of the sorted list store: entry cells, compare flags and output register.
`default_nettype none

`include "assert_macros.svh"

module sls_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sls_pkg::req_type      req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output sls_pkg::rsp_type           rsp_data,
   input  wire sls_pkg::ctrl_cmd_type cmd,
   output sls_pkg::dp_stat_type       stat
);

   localparam int CAP = sls_pkg::CAPACITY;
   localparam int CW  = sls_pkg::CNT_W;
   localparam int DW  = sls_pkg::DATA_W;

   logic signed [DW-1:0] entries_ff [CAP];
   logic signed [DW-1:0] entries_in [CAP];
   logic signed [DW-1:0] ins_next   [CAP];
   logic signed [DW-1:0] del_next   [CAP];
   logic signed [DW-1:0] rot_next   [CAP];
   logic [CAP-1:0]       lt_ff, lt_in, lt_cmp;
   logic [CAP-1:0]       eq_ff, eq_in, eq_cmp;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        dump_left_ff, dump_left_in;
   sls_pkg::req_type     req_ff, req_in;
   sls_pkg::rsp_type     rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 is_full;
   logic                 any_eq;

   assign is_full = (count_ff == CW'(CAP));
   assign any_eq  = |eq_ff;

   // Per-cell compare, insert shift, delete shift and dump rotation.
   for (genvar i = 0; i < CAP; i++) begin : g_cell
      logic                 in_range;
      logic                 prev_lt;
      logic signed [DW-1:0] lower;
      logic signed [DW-1:0] upper;

      assign in_range  = (CW'(i) < count_ff);
      assign lt_cmp[i] = in_range && (entries_ff[i] < req_ff.value);
      assign eq_cmp[i] = in_range && (entries_ff[i] == req_ff.value);

      if (i == 0) begin : g_first
         assign prev_lt = 1'b1;
         assign lower   = req_ff.value;
      end else begin : g_mid
         assign prev_lt = lt_ff[i-1];
         assign lower   = entries_ff[i-1];
      end

      if (i == CAP - 1) begin : g_top
         assign upper = entries_ff[i];
      end else begin : g_low
         assign upper = entries_ff[i+1];
      end

      // Entries below the insert point stay, the point takes the value, the rest move up.
      always_comb begin
         if (lt_ff[i]) begin
            ins_next[i] = entries_ff[i];
         end else if (prev_lt) begin
            ins_next[i] = req_ff.value;
         end else begin
            ins_next[i] = lower;
         end
      end

      // Since the list is sorted, the first equal entry is the first one not below the value.
      assign del_next[i] = lt_ff[i] ? entries_ff[i] : upper;

      // Rotate the held entries down by one, the head going to the tail.
      always_comb begin
         if (CW'(i + 1) == count_ff) begin
            rot_next[i] = entries_ff[0];
         end else if (CW'(i + 1) < count_ff) begin
            rot_next[i] = upper;
         end else begin
            rot_next[i] = entries_ff[i];
         end
      end
   end

   // Next-state logic of the datapath registers.
   always_comb begin
      entries_in   = entries_ff;
      lt_in        = lt_ff;
      eq_in        = eq_ff;
      count_in     = count_ff;
      dump_left_in = dump_left_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.load_req) begin
         req_in = req_data;
      end

      if (cmd.compare) begin
         lt_in = lt_cmp;
         eq_in = eq_cmp;
      end

      if (cmd.apply) begin
         rsp_in.data   = '0;
         rsp_in.status = sls_pkg::ST_DONE;
         rsp_in.found  = 1'b0;
         rsp_in.last   = 1'b1;
         case (req_ff.command)
            sls_pkg::CMD_INSERT: begin
               if (is_full) begin
                  rsp_in.status = sls_pkg::ST_FULL;
               end else begin
                  entries_in = ins_next;
                  count_in   = count_ff + 1'b1;
               end
            end
            sls_pkg::CMD_DELETE: begin
               if (any_eq) begin
                  entries_in = del_next;
                  count_in   = count_ff - 1'b1;
               end else begin
                  rsp_in.status = sls_pkg::ST_NOT_FOUND;
               end
            end
            sls_pkg::CMD_FIND: begin
               rsp_in.found = any_eq;
            end
            sls_pkg::CMD_DUMP: begin
               if (count_ff == '0) begin
                  rsp_in.status = sls_pkg::ST_EMPTY;
               end
               dump_left_in = count_ff;
            end
            default: begin
            end
         endcase
         rsp_in.occupancy = count_in;
         rsp_valid_in     = !stat.dump_go;
      end

      // One stored value per step, taken from the head of the rotating list.
      if (cmd.dump_step) begin
         rsp_in.data      = entries_ff[0];
         rsp_in.status    = sls_pkg::ST_DONE;
         rsp_in.found     = 1'b0;
         rsp_in.occupancy = count_ff;
         rsp_in.last      = stat.dump_last;
         entries_in       = rot_next;
         dump_left_in     = dump_left_ff - 1'b1;
         rsp_valid_in     = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      entries_ff   <= entries_in;
      lt_ff        <= lt_in;
      eq_ff        <= eq_in;
      dump_left_ff <= dump_left_in;
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
   end

   // Status to the controller and the result channel.
   assign stat.slot_free = !rsp_valid_ff || rsp_ready;
   assign stat.dump_go   = (req_ff.command == sls_pkg::CMD_DUMP) && (count_ff != '0);
   assign stat.dump_last = (dump_left_ff == CW'(1));
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_ff;

   // Assertions.
   `SLS_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(CAP))
   `SLS_ASSERT_NEXT(a_insert_grows, clock, reset,
      cmd.apply && (req_ff.command == sls_pkg::CMD_INSERT) && !is_full,
      count_ff == CW'($past(count_ff) + 1'b1))
   `SLS_ASSERT_NEXT(a_dump_keeps_count, clock, reset, cmd.dump_step, $stable(count_ff))
   `SLS_ASSERT(a_dump_not_over_slot, clock, reset, !(cmd.dump_step && !stat.slot_free))

endmodule

`default_nettype wire

### hw/rtl/sorted_list_store.sv
// Top level of the sorted list store: a sorted multiset of signed 32-bit values.
// Usage:
//   Requests arrive on req_valid / req_ready with req_data carrying a command
//   (insert, delete, find, dump) and a value. Results leave on rsp_valid /
//   rsp_ready with rsp_data carrying data, status, found, occupancy and last.
//   Insert, delete and find give one result each. A request passes through
//   the compare state, which compares the value with all cells at once, and
//   the apply state, which shifts the cells and loads the output register;
//   the next request is taken once the block is back in the idle state.
//   A dump of N entries gives N results, one per cycle while the receiver
//   takes them, by rotating the cells one place per result; an empty store
//   gives one empty result. When the receiver stalls, the result waits in the
//   output register and the block holds the next result until that one is
//   taken; a new request may be accepted meanwhile when the block is idle.
//   Synchronous reset empties the store and drops any pending result; there is
//   no clearing pass, since cells at or above the fill count are never read.
`default_nettype none

module sorted_list_store (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire sls_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output sls_pkg::rsp_type      rsp_data
);

   sls_pkg::ctrl_cmd_type cmd;
   sls_pkg::dp_stat_type  stat;

   // Controller sequencing each request.
   sls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Cell array and output register.
   sls_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

`default_nettype wire

### tb/sls_scoreboard_pkg.sv
// Scoreboard class that predicts and checks the results of the sorted list store.
`timescale 1ns / 1ps

package sls_scoreboard_pkg;

   import sls_pkg::*;

   class sorted_store_scoreboard;

      // Values the store should hold, kept in ascending signed order.
      logic signed [DATA_W-1:0] held_values[$];
      // Results still owed by the block, oldest first.
      rsp_type owed_results[$];
      int unsigned error_count;

      function new();
         error_count = 0;
      endfunction

      // Position of the first held value equal to the operand, or -1.
      function int position_of(logic signed [DATA_W-1:0] operand);
         foreach (held_values[i]) begin
            if (held_values[i] == operand) return i;
         end
         return -1;
      endfunction

      // A value currently held, so that deletes and finds can hit.
      function logic signed [DATA_W-1:0] pick_held();
         return held_values[$urandom_range(0, held_values.size() - 1)];
      endfunction

      function int unsigned owed_count();
         return owed_results.size();
      endfunction

      // Apply an accepted request to the expected contents and queue its results.
      function void note_request(req_type request);
         rsp_type result;
         int slot;
         result = '0;
         result.status = ST_DONE;
         result.last = 1'b1;
         case (request.command)
            CMD_INSERT: begin
               if (held_values.size() >= CAPACITY) begin
                  result.status = ST_FULL;
               end else begin
                  slot = 0;
                  while (slot < held_values.size() && held_values[slot] < request.value)
                     slot++;
                  held_values.insert(slot, request.value);
               end
            end
            CMD_DELETE: begin
               slot = position_of(request.value);
               if (slot < 0) result.status = ST_NOT_FOUND;
               else held_values.delete(slot);
            end
            CMD_FIND: begin
               result.found = (position_of(request.value) >= 0);
            end
            default: begin
               // A dump of an empty store gives one result marked empty.
               if (held_values.size() == 0) begin
                  result.status = ST_EMPTY;
               end else begin
                  result.occupancy = CNT_W'(held_values.size());
                  foreach (held_values[i]) begin
                     result.data = held_values[i];
                     result.last = (i == held_values.size() - 1);
                     owed_results.push_back(result);
                  end
                  return;
               end
            end
         endcase
         result.occupancy = CNT_W'(held_values.size());
         owed_results.push_back(result);
      endfunction

      // Compare an accepted result with the oldest one owed.
      function void check_result(rsp_type actual);
         rsp_type wanted;
         if (owed_results.size() == 0) begin
            $error("result with no request waiting: data %0d status %0d last %0d",
                   actual.data, actual.status, actual.last);
            error_count++;
            return;
         end
         wanted = owed_results.pop_front();
         if (actual.data !== wanted.data) begin
            $error("data: expected %0d, actual %0d", wanted.data, actual.data);
            error_count++;
         end
         if (actual.status !== wanted.status) begin
            $error("status: expected %0d, actual %0d", wanted.status, actual.status);
            error_count++;
         end
         if (actual.found !== wanted.found) begin
            $error("found: expected %0d, actual %0d", wanted.found, actual.found);
            error_count++;
         end
         if (actual.occupancy !== wanted.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", wanted.occupancy,
                   actual.occupancy);
            error_count++;
         end
         if (actual.last !== wanted.last) begin
            $error("last: expected %0d, actual %0d", wanted.last, actual.last);
            error_count++;
         end
      endfunction

   endclass

endpackage

### tb/sorted_list_store_test.sv
// Top-level testbench of the sorted list store with stimulus, stalls and end check.
`timescale 1ns / 1ps

module sorted_list_store_test;

   import sls_pkg::*;
   import sls_scoreboard_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned PHASE_ITEMS  = 40;
   localparam int unsigned DRAIN_CYCLES = 20;

   typedef enum {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Set for the final phase, where neither side idles.
   logic    calm_tail;
   int unsigned cycle_count;

   sorted_store_scoreboard store_model = new();

   sorted_list_store u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: a run that is still going at the limit has hung.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // Every accepted result goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) store_model.check_result(rsp_data);
   end

   // Result side: random stall bursts, with the stall odds drawn anew for each
   // stretch so that some stretches have no stalls at all.
   initial begin
      int unsigned stall_left;
      int unsigned stall_odds;
      int unsigned stretch_left;
      stall_left = 0;
      stall_odds = 0;
      stretch_left = 0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (stretch_left == 0) begin
            stretch_left = 50;
            stall_odds = $urandom_range(0, 2) * 4;
         end
         stretch_left--;
         if (calm_tail) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(1, 6) - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
         @(negedge clock);
      end
   end

   // Present one request and hold it until the block takes it.
   task automatic send_request(cmd_type command, logic signed [DATA_W-1:0] value);
      req_type request;
      request.command = command;
      request.value = value;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= request;
      do @(posedge clock); while (!req_ready);
      store_model.note_request(request);
   endtask

   // Leave the request side idle for the given number of cycles.
   task automatic idle_requests(int unsigned cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Operand mix: small values for collisions, extremes, and full-range values.
   function automatic logic signed [DATA_W-1:0] random_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $signed($urandom_range(0, 15)) - 8;
         4: begin
            case ($urandom_range(0, 5))
               0: return 32'sh8000_0000;
               1: return 32'sh8000_0001;
               2: return 32'sh7FFF_FFFF;
               3: return 32'sh7FFF_FFFE;
               4: return -32'sd1;
               default: return 32'sd0;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic cmd_type pick_command(mix_type mix);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL: begin
            if (roll < 80) return CMD_INSERT;
            if (roll < 88) return CMD_FIND;
            if (roll < 94) return CMD_DELETE;
            return CMD_DUMP;
         end
         MIX_DRAIN: begin
            if (roll < 15) return CMD_INSERT;
            if (roll < 70) return CMD_DELETE;
            if (roll < 90) return CMD_FIND;
            return CMD_DUMP;
         end
         default: begin
            if (roll < 35) return CMD_INSERT;
            if (roll < 60) return CMD_DELETE;
            if (roll < 88) return CMD_FIND;
            return CMD_DUMP;
         end
      endcase
   endfunction

   // Main sequence: reset, directed requests, random phases, then drain.
   initial begin
      mix_type phase_plan[8];
      cmd_type command;
      logic signed [DATA_W-1:0] operand;
      int unsigned idle_odds;
      phase_plan = '{MIX_FILL, MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_DRAIN,
                     MIX_BALANCED, MIX_FILL, MIX_BALANCED};
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      calm_tail = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty store: dump, delete and find all miss.
      send_request(CMD_DUMP, 32'sd0);
      send_request(CMD_DELETE, 32'sd5);
      send_request(CMD_FIND, 32'sd0);
      // Extremes and a duplicate.
      send_request(CMD_INSERT, 32'sh7FFF_FFFF);
      send_request(CMD_INSERT, 32'sh8000_0000);
      send_request(CMD_INSERT, 32'sd0);
      send_request(CMD_INSERT, -32'sd1);
      send_request(CMD_INSERT, 32'sd1);
      send_request(CMD_INSERT, 32'sd0);
      send_request(CMD_FIND, 32'sd0);
      send_request(CMD_FIND, 32'sd2);
      send_request(CMD_FIND, 32'sh7FFF_FFFF);
      send_request(CMD_DUMP, -32'sd1);
      // Deleting a duplicate removes only one copy.
      send_request(CMD_DELETE, 32'sd0);
      send_request(CMD_FIND, 32'sd0);
      send_request(CMD_DELETE, 32'sd0);
      send_request(CMD_FIND, 32'sd0);
      send_request(CMD_DELETE, 32'sd7);
      send_request(CMD_DELETE, 32'sh8000_0000);
      send_request(CMD_DELETE, 32'sh7FFF_FFFF);
      // Alternating bit patterns on the operand.
      send_request(CMD_INSERT, 32'sh5555_5555);
      send_request(CMD_INSERT, 32'shAAAA_AAAA);
      send_request(CMD_DUMP, 32'shFFFF_FFFF);

      // Random phases; the three fill phases favour inserts.
      foreach (phase_plan[p]) begin
         calm_tail = (p == 7);
         idle_odds = calm_tail ? 0 : $urandom_range(0, 2) * 4;
         repeat (PHASE_ITEMS) begin
            if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
               idle_requests($urandom_range(1, 6));
            command = pick_command(phase_plan[p]);
            if (command == CMD_INSERT || command == CMD_DUMP ||
                store_model.held_values.size() == 0 || $urandom_range(0, 3) == 0)
               operand = random_value();
            else
               operand = store_model.pick_held();
            send_request(command, operand);
         end
      end

      // Wait for every owed result, then a little longer for stray ones.
      @(negedge clock);
      req_valid <= 1'b0;
      while (store_model.owed_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (store_model.error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
